@@ rtl/psu_pkg.sv @@
`timescale 1ns / 1ps

package psu_pkg;

   // Fixed field widths
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned CFG_LINE_W    = 13;
   localparam int unsigned CFG_PIXEL_W   = 4;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned CSR_DATA_W    = 13;

   // Default sizes
   localparam int unsigned MAX_LINE_BYTES_DEF  = 4096;
   localparam int unsigned MAX_PIXEL_BYTES_DEF = 8;

   // Reset values of the configuration registers
   localparam logic [CFG_LINE_W-1:0]  LINE_BYTES_RST  = 13'd2;
   localparam logic [CFG_PIXEL_W-1:0] PIXEL_BYTES_RST = 4'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_BYTES = 2'd1;

   // Filter types as they appear in the filter byte
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filt_type;

   localparam logic [BYTE_W-1:0] FILT_LAST_KNOWN = 8'd4;

   // One accepted byte on its way from column tracking to reconstruction
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      filt_type          kind;
      logic              bad;
      logic              is_filter;
      logic              last;
      logic              have_above;
   } item_type;

endpackage

@@ rtl/psu_if.sv @@
`timescale 1ns / 1ps

interface psu_req_if;
   logic                        valid;
   logic                        ready;
   logic [psu_pkg::BYTE_W-1:0]  coded_byte;
   logic                        image_start;

   modport source (output valid, output coded_byte, output image_start, input ready);
   modport sink   (input valid, input coded_byte, input image_start, output ready);
endinterface

interface psu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [psu_pkg::BYTE_W-1:0]  plain_byte;
   logic                        is_filter_byte;
   logic                        row_end;
   logic                        bad_filter;

   modport source (output valid, output plain_byte, output is_filter_byte,
                   output row_end, output bad_filter, input ready);
   modport sink   (input valid, input plain_byte, input is_filter_byte,
                   input row_end, input bad_filter, output ready);
endinterface

interface psu_csr_if;
   logic                             valid;
   logic                             ready;
   logic [psu_pkg::CSR_INDEX_W-1:0]  index;
   logic [psu_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/png_scanline_unfilter.sv @@
`timescale 1ns / 1ps

// PNG scanline unfilter: takes the filtered stream one byte per word on req_bus (the filter
// type byte first in every row, image_start on the first byte of an image) and returns one
// word per byte on rsp_bus, the filter byte passed through and marked, every data byte rebuilt
// from its left, above and above-left neighbours under the None, Sub, Up, Average or Paeth
// rule; an unknown filter type passes the row raw with bad_filter set. Throughput is one byte
// per clock while rsp_bus.ready holds; the limit is the left-neighbour loop, which closes
// through the reconstruction stage and its pixel history. From accept to rsp valid a word
// passes the item register, loaded along with the synchronous line-store read of the byte
// above, and then the output register. The line store needs no clearing after reset; a row
// longer than any earlier row of the same image reads undefined above bytes. Write line_bytes
// and pixel_bytes on csr_bus only while no word is in flight.
module png_scanline_unfilter #(
   parameter int unsigned MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
   parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   psu_req_if.sink    req_bus,
   psu_rsp_if.source  rsp_bus,
   psu_csr_if.sink    csr_bus
);

   localparam int unsigned AW = $clog2(MAX_LINE_BYTES);

   logic [psu_pkg::CFG_LINE_W-1:0]  line_bytes_ff, line_bytes_in;
   logic [psu_pkg::CFG_PIXEL_W-1:0] pixel_bytes_ff, pixel_bytes_in;

   psu_pkg::item_type          item;
   logic                       item_valid;
   logic [AW-1:0]              item_idx;
   logic                       take;
   logic                       rd_en, wr_en;
   logic [AW-1:0]              rd_addr, wr_addr;
   logic [psu_pkg::BYTE_W-1:0] rd_data, wr_data;

   // configuration registers, always ready
   assign csr_bus.ready = 1'b1;

   always_comb begin
      line_bytes_in  = line_bytes_ff;
      pixel_bytes_in = pixel_bytes_ff;
      if (csr_bus.valid) begin
         if (csr_bus.index == psu_pkg::CSR_LINE_BYTES) begin
            line_bytes_in = csr_bus.data;
         end else if (csr_bus.index == psu_pkg::CSR_PIXEL_BYTES) begin
            pixel_bytes_in = csr_bus.data[psu_pkg::CFG_PIXEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff  <= psu_pkg::LINE_BYTES_RST;
         pixel_bytes_ff <= psu_pkg::PIXEL_BYTES_RST;
      end else begin
         line_bytes_ff  <= line_bytes_in;
         pixel_bytes_ff <= pixel_bytes_in;
      end
   end

   // Column tracking and the line-store read. The read for row r+1, column i always issues
   // after row r, column i was written back, since a filter byte lies between them, so no
   // forwarding path is needed.
   psu_col_track #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES)
   ) u_col_track (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .line_bytes (line_bytes_ff),
      .take       (take),
      .item       (item),
      .item_valid (item_valid),
      .item_idx   (item_idx),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   // previous row, one byte per column
   psu_line_store #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // predictor, pixel histories, write-back and output register
   psu_recon #(
      .MAX_LINE_BYTES  (MAX_LINE_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_recon (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .item_valid  (item_valid),
      .item_idx    (item_idx),
      .above_byte  (rd_data),
      .pixel_bytes (pixel_bytes_ff),
      .take        (take),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rsp_bus     (rsp_bus)
   );

`ifndef SYNTH
   // a filter byte never closes a row
   a_filter_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.is_filter_byte && rsp_bus.row_end))
      else $error("filter byte marked as row end");

   // the flag on a filter byte follows its own value
   a_filter_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_filter_byte) |->
         (rsp_bus.bad_filter == (rsp_bus.plain_byte > psu_pkg::FILT_LAST_KNOWN)))
      else $error("bad_filter disagrees with filter byte");

   // no word is taken while both stages are full and the output is stalled
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (item_valid && rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input accepted with pipeline full");

   // a line-store read always has a data byte waiting for it in the next cycle
   a_read_used: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (item_valid && !item.is_filter))
      else $error("line-store read without data byte in stage");
`endif

endmodule

@@ rtl/psu_line_store.sv @@
`timescale 1ns / 1ps

module psu_line_store #(
   parameter int unsigned MAX_LINE_BYTES = psu_pkg::MAX_LINE_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_LINE_BYTES)-1:0]    wr_addr,
   input  logic [psu_pkg::BYTE_W-1:0]           wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(MAX_LINE_BYTES)-1:0]    rd_addr,
   output logic [psu_pkg::BYTE_W-1:0]           rd_data
);

   logic [psu_pkg::BYTE_W-1:0] store_mem [MAX_LINE_BYTES];
   logic [psu_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/psu_col_track.sv @@
`timescale 1ns / 1ps

module psu_col_track #(
   parameter int unsigned MAX_LINE_BYTES = psu_pkg::MAX_LINE_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   psu_req_if.sink                              req_bus,
   input  logic [psu_pkg::CFG_LINE_W-1:0]       line_bytes,
   input  logic                                 take,
   output psu_pkg::item_type                    item,
   output logic                                 item_valid,
   output logic [$clog2(MAX_LINE_BYTES)-1:0]    item_idx,
   output logic                                 rd_en,
   output logic [$clog2(MAX_LINE_BYTES)-1:0]    rd_addr
);

   localparam int unsigned CW = $clog2(MAX_LINE_BYTES + 2);
   localparam int unsigned AW = $clog2(MAX_LINE_BYTES);
   localparam logic [31:0] LB_MAX = 32'(MAX_LINE_BYTES + 1);

   logic [CW-1:0]               col_ff, col_in, col_eff, col_dec, lb_last;
   logic                        have_ff, have_in, have_eff;
   logic [psu_pkg::BYTE_W-1:0]  row_type_ff, row_type_in;
   logic                        valid_ff, valid_in;
   psu_pkg::item_type           item_ff, item_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [31:0]                 lb_wide, lb_lim;
   logic                        accept, last;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   // clamp the line length
   always_comb begin
      lb_wide = 32'(line_bytes);
      if (lb_wide < 32'd2) begin
         lb_lim = 32'd2;
      end else if (lb_wide > LB_MAX) begin
         lb_lim = LB_MAX;
      end else begin
         lb_lim = lb_wide;
      end
      lb_last = CW'(lb_lim - 32'd1);
   end

   assign col_eff  = req_bus.image_start ? '0 : col_ff;
   assign have_eff = req_bus.image_start ? 1'b0 : have_ff;
   assign col_dec  = col_eff - CW'(1);
   assign last     = (col_eff >= lb_last);

   always_comb begin
      col_in            = col_ff;
      have_in           = have_ff;
      row_type_in       = row_type_ff;
      idx_in            = idx_ff;
      item_in           = item_ff;
      valid_in          = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in          = 1'b1;
         idx_in            = col_dec[AW-1:0];
         item_in.data      = req_bus.coded_byte;
         item_in.have_above = have_eff;
         if (col_eff == '0) begin
            row_type_in       = req_bus.coded_byte;
            item_in.is_filter = 1'b1;
            item_in.last      = 1'b0;
            item_in.bad       = (req_bus.coded_byte > psu_pkg::FILT_LAST_KNOWN);
            item_in.kind      = psu_pkg::FILT_NONE;
            col_in            = CW'(1);
            have_in           = have_eff;
         end else begin
            item_in.is_filter = 1'b0;
            item_in.last      = last;
            item_in.bad       = (row_type_ff > psu_pkg::FILT_LAST_KNOWN);
            // unknown types pass raw
            item_in.kind      = item_in.bad ? psu_pkg::FILT_NONE
                                            : psu_pkg::filt_type'(row_type_ff[2:0]);
            col_in            = last ? '0 : CW'(col_eff + CW'(1));
            have_in           = last ? 1'b1 : have_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         have_ff     <= 1'b0;
         row_type_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         col_ff      <= col_in;
         have_ff     <= have_in;
         row_type_ff <= row_type_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      idx_ff  <= idx_in;
   end

   // fetch the byte above together with the accept
   assign rd_en      = accept && (col_eff != '0);
   assign rd_addr    = col_dec[AW-1:0];
   assign item       = item_ff;
   assign item_valid = valid_ff;
   assign item_idx   = idx_ff;

endmodule

@@ rtl/psu_recon.sv @@
`timescale 1ns / 1ps

module psu_recon #(
   parameter int unsigned MAX_LINE_BYTES  = psu_pkg::MAX_LINE_BYTES_DEF,
   parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  psu_pkg::item_type                    item,
   input  logic                                 item_valid,
   input  logic [$clog2(MAX_LINE_BYTES)-1:0]    item_idx,
   input  logic [psu_pkg::BYTE_W-1:0]           above_byte,
   input  logic [psu_pkg::CFG_PIXEL_W-1:0]      pixel_bytes,
   output logic                                 take,
   output logic                                 wr_en,
   output logic [$clog2(MAX_LINE_BYTES)-1:0]    wr_addr,
   output logic [psu_pkg::BYTE_W-1:0]           wr_data,
   psu_rsp_if.source                            rsp_bus
);

   localparam int unsigned PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam logic [4:0]  PB_MAX = 5'(MAX_PIXEL_BYTES);
   localparam int unsigned BW = psu_pkg::BYTE_W;

   logic [BW-1:0] left_ff [MAX_PIXEL_BYTES];
   logic [BW-1:0] left_in [MAX_PIXEL_BYTES];
   logic [BW-1:0] al_ff   [MAX_PIXEL_BYTES];
   logic [BW-1:0] al_in   [MAX_PIXEL_BYTES];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] plain_ff;
   logic          filt_ff, end_ff, bad_ff;
   logic [4:0]    pb_wide, pb_lim, pb_dec;
   logic [PW-1:0] pb_sel;
   logic [BW-1:0] a, b, c, pred, val;
   logic [BW:0]   sum_ab;

   function automatic logic [BW-1:0] paeth(input logic [BW-1:0] pa_a,
                                           input logic [BW-1:0] pa_b,
                                           input logic [BW-1:0] pa_c);
      logic [BW:0] ab, cc, da, db, dc;
      ab = {1'b0, pa_a} + {1'b0, pa_b};
      cc = {1'b0, pa_c} + {1'b0, pa_c};
      da = (pa_b > pa_c) ? {1'b0, pa_b - pa_c} : {1'b0, pa_c - pa_b};
      db = (pa_a > pa_c) ? {1'b0, pa_a - pa_c} : {1'b0, pa_c - pa_a};
      dc = (ab > cc) ? (ab - cc) : (cc - ab);
      if (da <= db && da <= dc) begin
         return pa_a;
      end else if (db <= dc) begin
         return pa_b;
      end
      return pa_c;
   endfunction

   assign take = item_valid && (!rsp_valid_ff || rsp_bus.ready);

   // clamp the pixel size to 1..MAX_PIXEL_BYTES
   always_comb begin
      pb_wide = {1'b0, pixel_bytes};
      if (pb_wide == 5'd0) begin
         pb_lim = 5'd1;
      end else if (pb_wide > PB_MAX) begin
         pb_lim = PB_MAX;
      end else begin
         pb_lim = pb_wide;
      end
      pb_dec = pb_lim - 5'd1;
      pb_sel = pb_dec[PW-1:0];
   end

   assign a      = left_ff[pb_sel];
   assign c      = al_ff[pb_sel];
   assign b      = item.have_above ? above_byte : '0;
   assign sum_ab = {1'b0, a} + {1'b0, b};

   always_comb begin
      unique case (item.kind)
         psu_pkg::FILT_SUB:   pred = a;
         psu_pkg::FILT_UP:    pred = b;
         psu_pkg::FILT_AVG:   pred = sum_ab[BW:1];
         psu_pkg::FILT_PAETH: pred = paeth(a, b, c);
         default:             pred = '0;
      endcase
   end

   assign val = item.data + pred;

   // histories: clear at the filter byte, shift on each data byte
   always_comb begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         left_in[k] = left_ff[k];
         al_in[k]   = al_ff[k];
      end
      if (take) begin
         if (item.is_filter) begin
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               left_in[k] = '0;
               al_in[k]   = '0;
            end
         end else begin
            for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
               left_in[k] = left_ff[k-1];
               al_in[k]   = al_ff[k-1];
            end
            left_in[0] = val;
            al_in[0]   = b;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k] <= '0;
            al_ff[k]   <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k] <= left_in[k];
            al_ff[k]   <= al_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         plain_ff <= item.is_filter ? item.data : val;
         filt_ff  <= item.is_filter;
         end_ff   <= item.last;
         bad_ff   <= item.bad;
      end
   end

   // write back the rebuilt byte as the next row's above byte
   assign wr_en   = take && !item.is_filter;
   assign wr_addr = item_idx;
   assign wr_data = val;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.plain_byte     = plain_ff;
   assign rsp_bus.is_filter_byte = filt_ff;
   assign rsp_bus.row_end        = end_ff;
   assign rsp_bus.bad_filter     = bad_ff;

endmodule
